FILE: design/salru_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// salru_pkg
// shared types and constants of the set-associative lru tag store model
// ---------------------------------------------------------------------------
package salru_pkg;

   localparam int DEF_MAX_SET_BITS = 8;
   localparam int DEF_MAX_WAYS     = 8;
   localparam int DEF_ADDR_BITS    = 48;

   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 6;

   localparam logic [CSR_IDX_BITS-1:0] CSR_SET_BITS   = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_BLOCK_BITS = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_WAYS       = 2'd2;

   localparam logic [1:0] REQ_LOAD   = 2'd0;
   localparam logic [1:0] REQ_STORE  = 2'd1;
   localparam logic [1:0] REQ_MODIFY = 2'd2;
   localparam logic [1:0] REQ_IFETCH = 2'd3;

   localparam logic [1:0] OUT_HIT     = 2'd0;
   localparam logic [1:0] OUT_MISS    = 2'd1;
   localparam logic [1:0] OUT_EVICT   = 2'd2;
   localparam logic [1:0] OUT_IGNORED = 2'd3;

   localparam logic [31:0] TOTAL_MAX = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [1:0]               req_type;
      logic [DEF_ADDR_BITS-1:0] address;
   } req_type_type;

   typedef struct packed {
      logic [1:0]  outcome;
      logic        second_hit;
      logic [31:0] hit_count;
      logic [31:0] miss_count;
      logic [31:0] eviction_count;
   } rsp_type;

endpackage
`default_nettype wire

FILE: design/salru_ram.sv
`default_nettype none
// ---------------------------------------------------------------------------
// salru_ram
// generic single-port-write, single-port-read ram with registered read
// ---------------------------------------------------------------------------
module salru_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

FILE: design/salru_front.sv
`default_nettype none
// ---------------------------------------------------------------------------
// salru_front
// splits an access into set and tag and queues it for the back end
// ---------------------------------------------------------------------------
module salru_front #(
   parameter int MAX_SET_BITS = 8,
   parameter int ADDR_BITS    = 48
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output      logic                        req_ready,
   input  wire logic [1:0]                  in_type,
   input  wire logic [ADDR_BITS-1:0]        in_addr,
   input  wire logic [3:0]                  cfg_set_bits,
   input  wire logic [5:0]                  cfg_block_bits,
   output      logic                        q_valid,
   input  wire logic                        q_pop,
   output      logic [1:0]                  q_type,
   output      logic [MAX_SET_BITS-1:0]     q_set,
   output      logic [ADDR_BITS-1:0]        q_tag
);
   import salru_pkg::*;

   localparam int ENTRY_BITS = 2 + MAX_SET_BITS + ADDR_BITS;

   logic [ENTRY_BITS-1:0] slot_ff [2];
   logic [ENTRY_BITS-1:0] slot_in;
   logic                  wp_ff, rp_ff;
   logic [1:0]            cnt_ff;
   logic                  push;
   logic [5:0]            sb, bb;
   logic [ADDR_BITS-1:0]  above, tag;
   logic [MAX_SET_BITS-1:0] set, set_mask;

   // effective set and offset widths
   always_comb begin
      sb = (cfg_set_bits == 4'd0) ? 6'd1 : {2'b0, cfg_set_bits};
      if (32'(sb) > MAX_SET_BITS) sb = 6'(MAX_SET_BITS);
      bb = (cfg_block_bits == 6'd0) ? 6'd1 : cfg_block_bits;
   end

   // address split
   always_comb begin
      above    = (32'(bb) >= ADDR_BITS) ? '0 : (in_addr >> bb);
      set_mask = MAX_SET_BITS'(({{MAX_SET_BITS{1'b0}}, 1'b1} << sb) - 1'b1);
      set      = above[MAX_SET_BITS-1:0] & set_mask;
      tag      = above >> sb;
      slot_in  = {in_type, set, tag};
   end

   // two-entry queue
   assign req_ready = (cnt_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign q_valid   = (cnt_ff != 2'd0);
   assign {q_type, q_set, q_tag} = slot_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wp_ff] <= slot_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wp_ff <= ~wp_ff;
         if (q_pop) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(q_pop);
      end
   end
endmodule
`default_nettype wire

FILE: design/salru_back.sv
`default_nettype none
// ---------------------------------------------------------------------------
// salru_back
// reads a set row, decides hit or replacement, writes the row back
// ---------------------------------------------------------------------------
module salru_back #(
   parameter int MAX_SET_BITS = 8,
   parameter int MAX_WAYS     = 8,
   parameter int ADDR_BITS    = 48
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    q_valid,
   output      logic                    q_pop,
   input  wire logic [1:0]              q_type,
   input  wire logic [MAX_SET_BITS-1:0] q_set,
   input  wire logic [ADDR_BITS-1:0]    q_tag,
   input  wire logic [3:0]              cfg_ways,
   output      logic                    rsp_valid,
   input  wire logic                    rsp_ready,
   output      salru_pkg::rsp_type      rsp_data
);
   import salru_pkg::*;

   localparam int NSETS     = 1 << MAX_SET_BITS;
   localparam int WAY_BITS  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int RANK_BITS = WAY_BITS;
   localparam int ROW_BITS  = MAX_WAYS * (1 + ADDR_BITS + RANK_BITS);
   localparam int CLR_BITS  = MAX_SET_BITS + 1;
   localparam logic [RANK_BITS-1:0] RANK_TOP = RANK_BITS'(MAX_WAYS - 1);

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_READ  = 2'd2;
   localparam logic [1:0] ST_EXEC  = 2'd3;

   logic [1:0]              state_ff, state_in;
   logic [CLR_BITS-1:0]     clr_ff;
   logic [1:0]              type_ff;
   logic [MAX_SET_BITS-1:0] set_ff;
   logic [ADDR_BITS-1:0]    tag_ff;
   logic [31:0]             hit_ff, miss_ff, evict_ff;
   logic                    out_full_ff;
   rsp_type                 out_ff;

   logic                    wr_en;
   logic [MAX_SET_BITS-1:0] wr_addr, rd_addr;
   logic [ROW_BITS-1:0]     wr_row, rd_row;

   logic [MAX_WAYS-1:0]     v_old, v_new;
   logic [ADDR_BITS-1:0]    t_old [MAX_WAYS];
   logic [ADDR_BITS-1:0]    t_new [MAX_WAYS];
   logic [RANK_BITS-1:0]    r_old [MAX_WAYS];
   logic [RANK_BITS-1:0]    r_new [MAX_WAYS];
   logic [4:0]              ways;
   logic                    hit, free;
   logic [WAY_BITS-1:0]     way, hway, fway, oway;
   logic [RANK_BITS-1:0]    oldest, thr;
   logic [1:0]              outcome;
   logic                    is_mod;

   // the row of the item in flight stays addressed until its write-back
   assign rd_addr = (state_ff == ST_IDLE) ? q_set : set_ff;

   salru_ram #(.WIDTH(ROW_BITS), .DEPTH(NSETS)) u_rows (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_row),
      .rd_addr (rd_addr),
      .rd_data (rd_row)
   );

   // unpack the row and decide
   always_comb begin
      ways = (cfg_ways == 4'd0) ? 5'd1 : {1'b0, cfg_ways};
      if (32'(ways) > MAX_WAYS) ways = 5'(MAX_WAYS);
      hit = 1'b0; hway = '0; free = 1'b0; fway = '0;
      oldest = '0; oway = '0;
      for (int i = MAX_WAYS - 1; i >= 0; i--) begin
         v_old[i] = rd_row[i*(1+ADDR_BITS+RANK_BITS) + ADDR_BITS + RANK_BITS];
         t_old[i] = rd_row[i*(1+ADDR_BITS+RANK_BITS) + RANK_BITS +: ADDR_BITS];
         r_old[i] = rd_row[i*(1+ADDR_BITS+RANK_BITS) +: RANK_BITS];
         if (32'(i) < 32'(ways) && v_old[i] && t_old[i] == tag_ff) begin
            hit = 1'b1; hway = WAY_BITS'(i);
         end
         if (32'(i) < 32'(ways) && !v_old[i]) begin
            free = 1'b1; fway = WAY_BITS'(i);
         end
      end
      // oldest rank, lowest way on ties
      for (int i = 0; i < MAX_WAYS; i++) begin
         if (32'(i) < 32'(ways) && (i == 0 || r_old[i] > oldest)) begin
            oldest = r_old[i]; oway = WAY_BITS'(i);
         end
      end
      if (hit) begin
         way = hway; thr = r_old[hway]; outcome = OUT_HIT;
      end else if (free) begin
         way = fway; thr = RANK_TOP; outcome = OUT_MISS;
      end else begin
         way = oway; thr = oldest; outcome = OUT_EVICT;
      end
      // a free fill ages everything valid below the top rank, not only ranks under thr
      for (int i = 0; i < MAX_WAYS; i++) begin
         v_new[i] = v_old[i];
         t_new[i] = t_old[i];
         r_new[i] = r_old[i];
         if (32'(i) < 32'(ways)) begin
            if (WAY_BITS'(i) == way) begin
               v_new[i] = 1'b1;
               t_new[i] = tag_ff;
               r_new[i] = '0;
            end else if (v_old[i] && r_old[i] != RANK_TOP &&
                         ((!hit && free) || r_old[i] < thr)) begin
               r_new[i] = r_old[i] + 1'b1;
            end
         end
      end
      is_mod = (type_ff == REQ_MODIFY);
   end

   // row write: clearing pass or write-back
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = set_ff;
      wr_row  = '0;
      if (state_ff == ST_CLEAR) begin
         wr_en   = 1'b1;
         wr_addr = clr_ff[MAX_SET_BITS-1:0];
      end else if (state_ff == ST_EXEC) begin
         wr_en = 1'b1;
         for (int i = 0; i < MAX_WAYS; i++) begin
            wr_row[i*(1+ADDR_BITS+RANK_BITS) +: 1+ADDR_BITS+RANK_BITS] =
               {v_new[i], t_new[i], r_new[i]};
         end
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      q_pop    = 1'b0;
      unique case (state_ff)
         ST_CLEAR: if (clr_ff == CLR_BITS'(NSETS - 1)) state_in = ST_IDLE;
         ST_IDLE: begin
            if (q_valid && (!out_full_ff || rsp_ready)) begin
               q_pop = 1'b1;
               state_in = (q_type == REQ_IFETCH) ? ST_IDLE : ST_READ;
            end
         end
         ST_READ: state_in = ST_EXEC;
         ST_EXEC: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   function automatic logic [31:0] bump(input logic [31:0] v, input logic en);
      return (en && v != TOTAL_MAX) ? v + 32'd1 : v;
   endfunction

   always_ff @(posedge clock) begin
      if (q_pop) begin
         type_ff <= q_type;
         set_ff  <= q_set;
         tag_ff  <= q_tag;
      end
   end

   // totals, output register and control
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         clr_ff      <= '0;
         out_full_ff <= 1'b0;
         hit_ff      <= '0;
         miss_ff     <= '0;
         evict_ff    <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) clr_ff <= clr_ff + 1'b1;
         if (rsp_valid && rsp_ready) out_full_ff <= 1'b0;
         if (q_pop && q_type == REQ_IFETCH) begin
            out_full_ff <= 1'b1;
            out_ff <= '{OUT_IGNORED, 1'b0, hit_ff, miss_ff, evict_ff};
         end
         if (state_ff == ST_EXEC) begin
            hit_ff   <= bump(bump(hit_ff, hit), is_mod);
            miss_ff  <= bump(miss_ff, !hit);
            evict_ff <= bump(evict_ff, !hit && !free);
            out_full_ff <= 1'b1;
            out_ff <= '{outcome, is_mod, bump(bump(hit_ff, hit), is_mod),
                        bump(miss_ff, !hit), bump(evict_ff, !hit && !free)};
         end
      end
   end

   assign rsp_valid = out_full_ff;
   assign rsp_data  = out_ff;
endmodule
`default_nettype wire

FILE: design/set_assoc_cache_lru_model.sv
`default_nettype none
// ---------------------------------------------------------------------------
// set_assoc_cache_lru_model
// lru tag store of a set-associative cache with hit, miss, eviction totals
// ---------------------------------------------------------------------------
// channel   dir  handshake          payload
// req_      in   req_valid/ready    req_type_type
// rsp_      out  rsp_valid/ready    rsp_type
// csr_      in   csr_wr_en          csr_index, csr_data
//
// in the back end a data access reads its set row, then decides and writes
// back in one step; a modify's second hit is folded into it.
// an instruction fetch skips the row. a 2-entry queue decouples the front.
// after reset a pass clears all 2^MAX_SET_BITS set rows before items go.
// a full output register stalls the back end; the front keeps filling.
// ---------------------------------------------------------------------------
module set_assoc_cache_lru_model #(
   parameter int MAX_SET_BITS = salru_pkg::DEF_MAX_SET_BITS,
   parameter int MAX_WAYS     = salru_pkg::DEF_MAX_WAYS
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output      logic                                 req_ready,
   input  wire salru_pkg::req_type_type              req_data,
   output      logic                                 rsp_valid,
   input  wire logic                                 rsp_ready,
   output      salru_pkg::rsp_type                   rsp_data,
   input  wire logic                                 csr_wr_en,
   input  wire logic [salru_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  wire logic [salru_pkg::CSR_DATA_BITS-1:0]  csr_data
);
   import salru_pkg::*;

   localparam int ADDR_BITS = DEF_ADDR_BITS;

   logic [3:0] set_bits_ff, ways_ff;
   logic [5:0] block_bits_ff;
   logic                    q_valid, q_pop;
   logic [1:0]              q_type;
   logic [MAX_SET_BITS-1:0] q_set;
   logic [ADDR_BITS-1:0]    q_tag;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         set_bits_ff   <= 4'd4;
         block_bits_ff <= 6'd4;
         ways_ff       <= 4'd1;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_SET_BITS:   set_bits_ff   <= csr_data[3:0];
            CSR_BLOCK_BITS: block_bits_ff <= csr_data;
            CSR_WAYS:       ways_ff       <= csr_data[3:0];
            default: ;
         endcase
      end
   end

   salru_front #(.MAX_SET_BITS(MAX_SET_BITS), .ADDR_BITS(ADDR_BITS)) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .in_type        (req_data.req_type),
      .in_addr        (req_data.address),
      .cfg_set_bits   (set_bits_ff),
      .cfg_block_bits (block_bits_ff),
      .q_valid        (q_valid),
      .q_pop          (q_pop),
      .q_type         (q_type),
      .q_set          (q_set),
      .q_tag          (q_tag)
   );

   salru_back #(.MAX_SET_BITS(MAX_SET_BITS), .MAX_WAYS(MAX_WAYS),
                .ADDR_BITS(ADDR_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_pop     (q_pop),
      .q_type    (q_type),
      .q_set     (q_set),
      .q_tag     (q_tag),
      .cfg_ways  (ways_ff),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );
endmodule
`default_nettype wire

FILE: design/salru_checker.sv
`default_nettype none
// ---------------------------------------------------------------------------
// salru_checker
// port-level checks of the lru model, bound to the top level
// ---------------------------------------------------------------------------
module salru_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire salru_pkg::rsp_type rsp_data
);
   import salru_pkg::*;

   // held result stays put
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // second hit only on non-ignored items
   a_second: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.second_hit |-> rsp_data.outcome != OUT_IGNORED)
      else $error("second hit on ignored item");

   // an eviction is also a miss, so evictions never exceed misses
   a_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.eviction_count <= rsp_data.miss_count)
      else $error("evictions above misses");

   // ignored items leave the miss total unchanged versus the previous result
   a_ign: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready ##1 rsp_valid && rsp_data.outcome == OUT_IGNORED
      |-> rsp_data.miss_count == $past(rsp_data.miss_count))
      else $error("ignored item moved the totals");
endmodule

bind set_assoc_cache_lru_model salru_checker u_chk (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
`default_nettype wire

FILE: bench/testbench.sv
`default_nettype none
// ---------------------------------------------------------------------------
// testbench
// checks the lru tag store model against its own predictor of the cache
// ---------------------------------------------------------------------------
// each item accepted on the req_ channel drives a predicted response into a
// queue. responses on the rsp_ channel are compared field by field against
// that queue in order. the run has a directed part, then random phases under
// several cache shapes, the extremes among them. both sides idle at random.
// ---------------------------------------------------------------------------
module testbench;
   import salru_pkg::*;

   localparam int NSETS   = 1 << DEF_MAX_SET_BITS;
   localparam int NWAYS   = DEF_MAX_WAYS;
   localparam int WDOG    = 5000;
   localparam logic [63:0] ADDR_MASK = (64'd1 << DEF_ADDR_BITS) - 1;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   req_type_type             req_data = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   rsp_type                  rsp_data;
   logic                     csr_wr_en = 1'b0;
   logic [CSR_IDX_BITS-1:0]  csr_index = CSR_SET_BITS;
   logic [CSR_DATA_BITS-1:0] csr_data = '0;

   // predictor copy of the tag store and the registers
   logic        line_held [NSETS][NWAYS];
   logic [63:0] line_tags [NSETS][NWAYS];
   int          age       [NSETS][NWAYS];
   logic [31:0] hits, misses, evictions;
   int          cfg_sets, cfg_block, cfg_ways;

   rsp_type     expected_rsps[$];
   int          errors = 0;
   int          idle_cycles = 0;
   bit          req_gaps = 1'b0;
   bit          rsp_stalls = 1'b0;
   int          stall_left = 0;

   set_assoc_cache_lru_model dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_data(csr_data)
   );

   always #4 clock = ~clock;

   function automatic logic [31:0] bump(logic [31:0] t);
      return (t == TOTAL_MAX) ? t : t + 1;
   endfunction

   function automatic int eff_sets();
      int s;
      s = (cfg_sets == 0) ? 1 : cfg_sets;
      return (s > DEF_MAX_SET_BITS) ? DEF_MAX_SET_BITS : s;
   endfunction

   function automatic int eff_ways();
      int w;
      w = (cfg_ways == 0) ? 1 : cfg_ways;
      return (w > NWAYS) ? NWAYS : w;
   endfunction

   // make a way most recent, younger valid ways age by one
   function automatic void make_recent(int s, int w, int ways, int old_age);
      for (int i = 0; i < ways; i++)
         if (i != w && line_held[s][i] && age[s][i] < old_age && age[s][i] < NWAYS - 1)
            age[s][i]++;
      age[s][w] = 0;
   endfunction

   function automatic rsp_type predict_access(req_type_type r);
      rsp_type     res;
      int          sb, bb, ways, s, way;
      logic [63:0] above, tg;
      bit          hit, free;
      res = '0;
      res.outcome = OUT_IGNORED;
      if (r.req_type != REQ_IFETCH) begin
         sb = eff_sets();
         bb = (cfg_block == 0) ? 1 : cfg_block;
         ways = eff_ways();
         above = {16'd0, r.address} >> bb;
         s = int'(above & ((64'd1 << sb) - 1));
         tg = above >> sb;
         hit = 1'b0;
         way = 0;
         for (int i = 0; i < ways && !hit; i++)
            if (line_held[s][i] && line_tags[s][i] == tg) begin
               hit = 1'b1;
               way = i;
            end
         if (hit) begin
            res.outcome = OUT_HIT;
            hits = bump(hits);
            make_recent(s, way, ways, age[s][way]);
         end else begin
            misses = bump(misses);
            free = 1'b0;
            for (int i = 0; i < ways && !free; i++)
               if (!line_held[s][i]) begin
                  free = 1'b1;
                  way = i;
               end
            if (free) begin
               res.outcome = OUT_MISS;
               line_held[s][way] = 1'b1;
               line_tags[s][way] = tg;
               make_recent(s, way, ways, NWAYS);
            end else begin
               int oldest;
               oldest = 0;
               res.outcome = OUT_EVICT;
               evictions = bump(evictions);
               for (int i = 0; i < ways; i++)
                  if (i == 0 || age[s][i] > oldest) begin
                     oldest = age[s][i];
                     way = i;
                  end
               line_tags[s][way] = tg;
               make_recent(s, way, ways, oldest);
            end
         end
         // second access of a modify always hits
         if (r.req_type == REQ_MODIFY) begin
            res.second_hit = 1'b1;
            hits = bump(hits);
            make_recent(s, way, ways, age[s][way]);
         end
      end
      res.hit_count = hits;
      res.miss_count = misses;
      res.eviction_count = evictions;
      return res;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // address built from a small pool of tags and sets so lines get reused
   function automatic logic [47:0] pool_address(int ntags, int nsets);
      int          sb, bb;
      logic [63:0] a;
      if ($urandom_range(0, 9) == 0)
         return 48'({$urandom, $urandom} & ADDR_MASK);
      sb = eff_sets();
      bb = (cfg_block == 0) ? 1 : cfg_block;
      a = (64'($urandom_range(0, ntags - 1)) << (bb + sb))
          | ((64'($urandom_range(0, nsets - 1)) & ((64'd1 << sb) - 1)) << bb)
          | ({$urandom, $urandom} & ((64'd1 << bb) - 1));
      return 48'(a & ADDR_MASK);
   endfunction

   // response side: random stalls, checking against the oldest prediction
   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsps.size() == 0) begin
            $error("response with none expected");
            errors++;
         end else begin
            exp_rsp = expected_rsps.pop_front();
            if (rsp_data.outcome !== exp_rsp.outcome) begin
               $error("outcome: expected %0d, got %0d", exp_rsp.outcome, rsp_data.outcome);
               errors++;
            end
            if (rsp_data.second_hit !== exp_rsp.second_hit) begin
               $error("second_hit: expected %0d, got %0d",
                      exp_rsp.second_hit, rsp_data.second_hit);
               errors++;
            end
            if (rsp_data.hit_count !== exp_rsp.hit_count) begin
               $error("hit_count: expected %0d, got %0d",
                      exp_rsp.hit_count, rsp_data.hit_count);
               errors++;
            end
            if (rsp_data.miss_count !== exp_rsp.miss_count) begin
               $error("miss_count: expected %0d, got %0d",
                      exp_rsp.miss_count, rsp_data.miss_count);
               errors++;
            end
            if (rsp_data.eviction_count !== exp_rsp.eviction_count) begin
               $error("eviction_count: expected %0d, got %0d",
                      exp_rsp.eviction_count, rsp_data.eviction_count);
               errors++;
            end
         end
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (rsp_stalls) begin
         stall_left = pick_gap();
         rsp_ready <= (stall_left == 0);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // watchdog on cycles with no item moving
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG) begin
         $display("testbench NOT OK");
         $finish;
      end
   end

   // send one item; called at a rising edge, returns at its accepting edge
   task automatic send_item(logic [1:0] kind, logic [47:0] addr);
      req_type_type item;
      int           gap;
      gap = req_gaps ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      item.req_type = kind;
      item.address = addr;
      req_valid <= 1'b1;
      req_data <= item;
      forever begin
         @(posedge clock);
         if (req_ready) break;
      end
      expected_rsps.push_back(predict_access(item));
   endtask

   // let every response drain, then the back end settle
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_BITS-1:0] idx, int value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_data <= CSR_DATA_BITS'(value);
      case (idx)
         CSR_SET_BITS:   cfg_sets = value & 15;
         CSR_BLOCK_BITS: cfg_block = value & 63;
         default:        cfg_ways = value & 15;
      endcase
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_shape(int sb, int bb, int ways);
      wait_idle();
      write_csr(CSR_SET_BITS, sb);
      write_csr(CSR_BLOCK_BITS, bb);
      write_csr(CSR_WAYS, ways);
   endtask

   // hit, miss, eviction and modify under the reset shape, plus fetches
   task automatic test_basic_access();
      send_item(REQ_LOAD, 48'h0);
      send_item(REQ_LOAD, 48'h8);
      send_item(REQ_STORE, 48'h100);
      send_item(REQ_MODIFY, 48'h100);
      send_item(REQ_MODIFY, 48'h200);
      send_item(REQ_IFETCH, 48'h200);
      send_item(REQ_IFETCH, 48'hFFFF_FFFF_FFFF);
      send_item(REQ_LOAD, 48'hFFFF_FFFF_FFFF);
      send_item(REQ_STORE, 48'hFFFF_FFFF_FFFF);
      send_item(REQ_LOAD, 48'hAAAA_AAAA_AAAA);
      send_item(REQ_LOAD, 48'h5555_5555_5555);
   endtask

   // fill all ways of one set, reorder by hits, then evict in lru order
   task automatic test_lru_order();
      set_shape(2, 3, 8);
      for (int t = 0; t < 8; t++) send_item(REQ_LOAD, 48'(t << 5));
      send_item(REQ_LOAD, 48'(3 << 5));
      send_item(REQ_MODIFY, 48'(0 << 5));
      for (int t = 8; t < 11; t++) send_item(REQ_STORE, 48'(t << 5));
      // shrink while lines are held, then grow back
      set_shape(2, 3, 3);
      send_item(REQ_LOAD, 48'(7 << 5));
      send_item(REQ_LOAD, 48'(12 << 5));
      set_shape(2, 3, 8);
      send_item(REQ_LOAD, 48'(7 << 5));
   endtask

   // register values outside the normal range and at the field limits
   task automatic test_shape_extremes();
      set_shape(0, 0, 0);
      send_item(REQ_LOAD, 48'h3);
      send_item(REQ_LOAD, 48'h7);
      set_shape(15, 63, 15);
      send_item(REQ_LOAD, 48'hFFFF_FFFF_FFFF);
      send_item(REQ_MODIFY, 48'h0);
      set_shape(8, 32, 8);
      send_item(REQ_LOAD, 48'hFFFF_0000_0000);
   endtask

   task automatic run_phase(int items);
      int r;
      logic [1:0] kind;
      req_gaps = $urandom_range(0, 3) != 0;
      rsp_stalls = $urandom_range(0, 3) != 0;
      for (int n = 0; n < items; n++) begin
         r = $urandom_range(0, 9);
         kind = (r < 4) ? REQ_LOAD : (r < 7) ? REQ_STORE : (r < 9) ? REQ_MODIFY : REQ_IFETCH;
         send_item(kind, pool_address(eff_ways() + 3, 4));
      end
   endtask

   // random traffic under several shapes; the sender pauses between phases
   task automatic test_random_traffic();
      int sb, bb, ways;
      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0: begin sb = 8; bb = 32; ways = 8; end
            1: begin sb = 1; bb = 1; ways = 1; end
            2: begin sb = 1; bb = 1; ways = 8; end
            default: begin
               if ($urandom_range(0, 3) == 0) begin
                  sb = $urandom_range(0, 15);
                  bb = $urandom_range(0, 63);
                  ways = $urandom_range(0, 15);
               end else begin
                  sb = $urandom_range(1, 8);
                  bb = $urandom_range(1, 32);
                  ways = $urandom_range(1, 8);
               end
            end
         endcase
         set_shape(sb, bb, ways);
         run_phase(128);
      end
   endtask

   initial begin
      for (int s = 0; s < NSETS; s++)
         for (int w = 0; w < NWAYS; w++) begin
            line_held[s][w] = 1'b0;
            line_tags[s][w] = '0;
            age[s][w] = 0;
         end
      hits = '0;
      misses = '0;
      evictions = '0;
      cfg_sets = 4;
      cfg_block = 4;
      cfg_ways = 1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_basic_access();
      test_lru_order();
      test_shape_extremes();
      test_random_traffic();
      wait_idle();
      if (errors == 0)
         $display("testbench OK");
      else
         $display("testbench NOT OK");
      $finish;
   end

endmodule
`default_nettype wire

FILE: set_assoc_cache_lru_model.f
design/salru_pkg.sv
design/salru_ram.sv
design/salru_front.sv
design/salru_back.sv
design/set_assoc_cache_lru_model.sv
design/salru_checker.sv
bench/testbench.sv
